// File: rtl/core/abp_pkg.sv
// Package for the active Brownian particle step: types, constants, CORDIC table.
// No dependencies.
`default_nettype none
package abp_pkg;
	localparam int CordicStagesDef = 16;
	localparam int TableLen = 24;
	localparam logic signed [31:0] TurnsPerRad = 32'sd683565276;
	localparam logic signed [31:0] CordicInvGain = 32'sd652032874;
	localparam logic [2:0] RegRotScale = 3'd0;
	localparam logic [2:0] RegTransScale = 3'd1;
	localparam logic [2:0] RegDriveGain = 3'd2;
	localparam logic [2:0] RegForceGain = 3'd3;
	localparam logic [2:0] RegInvStep = 3'd4;

	// vector and residual angle as they pass between CORDIC cells
	typedef struct packed {
		logic signed [33:0] x;
		logic signed [33:0] y;
		logic signed [33:0] z;
	} cvec_t;

	function automatic logic [31:0] atan_turn(input int i);
		logic [31:0] r;
		begin
			r = 32'd0;
			case (i)
				0: r = 32'd536870912;  1: r = 32'd316933406;  2: r = 32'd167458907;
				3: r = 32'd85004756;   4: r = 32'd42667331;   5: r = 32'd21354465;
				6: r = 32'd10679838;   7: r = 32'd5340245;    8: r = 32'd2670163;
				9: r = 32'd1335087;    10: r = 32'd667544;    11: r = 32'd333772;
				12: r = 32'd166886;    13: r = 32'd83443;     14: r = 32'd41722;
				15: r = 32'd20861;     16: r = 32'd10430;     17: r = 32'd5215;
				18: r = 32'd2608;      19: r = 32'd1304;      20: r = 32'd652;
				21: r = 32'd326;       22: r = 32'd163;       23: r = 32'd81;
				default: r = 32'd0;
			endcase
			return r;
		end
	endfunction
endpackage
`default_nettype wire

// File: rtl/core/abp_cell.sv
// One CORDIC rotation cell: a single micro-rotation, registered.
// Depends on abp_pkg.
`default_nettype none
module abp_cell import abp_pkg::*; #(
	parameter int Idx = 0
) (
	input  wire   clk,
	input  cvec_t din,
	output cvec_t dout
);
	localparam logic signed [33:0] Ang = $signed({2'b00, atan_turn(Idx)});
	always_ff @(posedge clk) begin
		if (!din.z[33]) begin
			dout.x <= din.x - (din.y >>> Idx);
			dout.y <= din.y + (din.x >>> Idx);
			dout.z <= din.z - Ang;
		end else begin
			dout.x <= din.x + (din.y >>> Idx);
			dout.y <= din.y - (din.x >>> Idx);
			dout.z <= din.z + Ang;
		end
	end
endmodule
`default_nettype wire

// File: rtl/core/abp_rotator.sv
// Rotator: quadrant swap, chain of CORDIC cells, gain compensation, rounding.
// Depends on abp_pkg, abp_cell.
`default_nettype none
module abp_rotator import abp_pkg::*; #(
	parameter int Stages = CordicStagesDef
) (
	input  wire                clk,
	input  wire signed  [33:0] x_in,
	input  wire signed  [33:0] y_in,
	input  wire         [31:0] ang,
	output logic signed [15:0] x_out,
	output logic signed [15:0] y_out
);
	localparam int Used = (Stages < TableLen) ? Stages : TableLen;
	cvec_t chain [0:Used];
	logic [1:0]  q;
	logic [31:0] d;
	cvec_t pre;
	logic signed [63:0] mx_s1, my_s1;

	always_comb begin
		q = 2'((ang + 32'h2000_0000) >> 30);
		d = ang - {q, 30'd0};
		pre.z = {{2{d[31]}}, d};
		case (q)
			2'd1: begin pre.x = -y_in; pre.y = x_in; end
			2'd2: begin pre.x = -x_in; pre.y = -y_in; end
			2'd3: begin pre.x = y_in; pre.y = -x_in; end
			default: begin pre.x = x_in; pre.y = y_in; end
		endcase
	end

	always_ff @(posedge clk) chain[0] <= pre;

	for (genvar i = 0; i < Used; i++) begin : g_cell
		abp_cell #(.Idx(i)) u_cell (.clk(clk), .din(chain[i]), .dout(chain[i+1]));
	end

	function automatic logic signed [15:0] finish(input logic signed [63:0] m);
		logic signed [63:0] r;
		begin
			r = (m + 64'sd35184372088832) >>> 46;
			if (r < -64'sd16384) return -16'sd16384;
			if (r > 64'sd16384) return 16'sd16384;
			return r[15:0];
		end
	endfunction

	always_ff @(posedge clk) begin
		mx_s1 <= 64'(chain[Used].x) * 64'(CordicInvGain);
		my_s1 <= 64'(chain[Used].y) * 64'(CordicInvGain);
		x_out <= finish(mx_s1);
		y_out <= finish(my_s1);
	end
endmodule
`default_nettype wire

// File: rtl/core/abp_axis.sv
// One axis of the position update: displacement, saturated position, velocity.
// Depends on abp_pkg.
`default_nettype none
module abp_axis import abp_pkg::*; (
	input  wire                clk,
	input  wire signed  [15:0] dir,
	input  wire signed  [31:0] force_in,
	input  wire signed  [15:0] noise,
	input  wire signed  [31:0] pos,
	input  wire         [31:0] drive_gain,
	input  wire         [31:0] force_gain,
	input  wire         [31:0] trans_scale,
	input  wire         [31:0] inv_step,
	output logic signed [31:0] new_pos,
	output logic signed [31:0] vel
);
	logic signed [49:0] drv_s1;
	logic signed [64:0] psh_s1;
	logic signed [48:0] jit_s1;
	logic signed [31:0] pos_s1, pos_s2, pos_s3, pos_s4;
	logic signed [66:0] d_s2;
	logic               neg_s3, neg_s4;
	logic        [66:0] mag_s3;
	logic signed [66:0] d_s3;
	logic signed [66:0] np_c;
	logic        [70:0] hi_s4;
	logic        [59:0] lo_s4;
	logic        [70:0] mag_c;
	logic signed [71:0] pa_s4;

	always_ff @(posedge clk) begin
		drv_s1 <= $signed({1'b0, drive_gain}) * dir;
		psh_s1 <= $signed({1'b0, force_gain}) * force_in;
		jit_s1 <= $signed({1'b0, trans_scale}) * noise;
		pos_s1 <= pos;
		d_s2 <= 67'(drv_s1 >>> 2) + 67'(psh_s1 >>> 4) + 67'(jit_s1);
		pos_s2 <= pos_s1;
		d_s3 <= d_s2;
		neg_s3 <= d_s2[66];
		mag_s3 <= d_s2[66] ? 67'(-d_s2) : 67'(d_s2);
		pos_s3 <= pos_s2;
		// |displacement| stays below 2^60, so the integer part fits 32 bits
		hi_s4 <= 71'(mag_s3[59:28]) * 71'(inv_step);
		lo_s4 <= (60'(mag_s3[27:0]) * 60'(inv_step) + 60'd134217728) >> 28;
		neg_s4 <= neg_s3;
		pa_s4 <= 72'(pos_s3) + 72'((d_s3 + 67'sd2048) >>> 12);
		pos_s4 <= pos_s3;
	end

	always_comb begin
		mag_c = (hi_s4 >= 71'h1_0000_0000) ? 71'h1_0000_0000 : hi_s4 + 71'(lo_s4);
		np_c = 67'(pa_s4);
	end

	always_ff @(posedge clk) begin
		if (pa_s4 < -72'sh8000_0000) new_pos <= 32'sh8000_0000;
		else if (pa_s4 > 72'sh7FFF_FFFF) new_pos <= 32'sh7FFF_FFFF;
		else new_pos <= np_c[31:0];
		if (neg_s4) vel <= (mag_c >= 71'h8000_0000) ? 32'sh8000_0000 : -$signed(mag_c[31:0]);
		else vel <= (mag_c >= 71'h7FFF_FFFF) ? 32'sh7FFF_FFFF : mag_c[31:0];
	end
endmodule
`default_nettype wire

// File: rtl/core/active_brownian_particle_step_2d.sv
// Top level of the active Brownian particle step: init rotator, noise rotator, axes.
// Depends on abp_pkg, abp_rotator, abp_axis.
//
// channel | handshake            | payload
// config  | cfg_we               | cfg_index, cfg_data
// input   | start & !busy        | pos_x .. in_group
// result  | done (one cycle)     | new_pos_x .. moved
//
// One particle accepted per cycle; busy is never raised.
// Each particle passes through the two CORDIC cell chains in series (init rotator, then the
// angle product and the noise rotator), the axis multipliers and the output registers.
// Reset clears the config registers (inv_step to 65536) and the valid line; payload registers are not reset.
// The receiver cannot stall; done pulses for exactly one cycle per transfer.
`default_nettype none
module active_brownian_particle_step_2d import abp_pkg::*; #(
	parameter int CORDIC_STAGES = CordicStagesDef
) (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                cfg_we,
	input  wire         [2:0]  cfg_index,
	input  wire         [31:0] cfg_data,
	input  wire                start,
	output logic               busy,
	input  wire signed  [31:0] pos_x,
	input  wire signed  [31:0] pos_y,
	input  wire signed  [15:0] dir_x,
	input  wire signed  [15:0] dir_y,
	input  wire signed  [31:0] force_x,
	input  wire signed  [31:0] force_y,
	input  wire signed  [15:0] noise_rot,
	input  wire signed  [15:0] noise_x,
	input  wire signed  [15:0] noise_y,
	input  wire         [15:0] init_angle,
	input  wire                init_orient,
	input  wire                in_group,
	output logic               done,
	output logic signed [31:0] new_pos_x,
	output logic signed [31:0] new_pos_y,
	output logic signed [15:0] new_dir_x,
	output logic signed [15:0] new_dir_y,
	output logic signed [31:0] vel_x,
	output logic signed [31:0] vel_y,
	output logic               moved
);
	localparam int Used = (CORDIC_STAGES < TableLen) ? CORDIC_STAGES : TableLen;
	localparam int RotLat = Used + 3;
	// stage A: init rotator; stage B: noise rotator, with the angle product registers in front
	localparam int LatA = RotLat;
	localparam int LatB = RotLat;
	localparam int AxLat = 5;
	localparam int Total = LatA + 2 + LatB + AxLat + 1;

	logic [15:0] rot_scale_q;
	logic [31:0] trans_scale_q, drive_gain_q, force_gain_q, inv_step_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rot_scale_q <= '0; trans_scale_q <= '0; drive_gain_q <= '0;
			force_gain_q <= '0; inv_step_q <= 32'd65536;
		end else if (cfg_we) begin
			unique case (cfg_index)
				RegRotScale:   rot_scale_q <= cfg_data[15:0];
				RegTransScale: trans_scale_q <= cfg_data;
				RegDriveGain:  drive_gain_q <= cfg_data;
				RegForceGain:  force_gain_q <= cfg_data;
				RegInvStep:    inv_step_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign busy = 1'b0;
	wire take = start & ~busy;

	// payload carried alongside the first rotator
	typedef struct packed {
		logic signed [31:0] px, py, fx, fy;
		logic signed [15:0] ux, uy, nr, nx, ny;
		logic init, grp;
	} item_t;

	item_t item_in;
	assign item_in = '{px: pos_x, py: pos_y, fx: force_x, fy: force_y, ux: dir_x, uy: dir_y,
		nr: noise_rot, nx: noise_x, ny: noise_y, init: init_orient, grp: in_group};

	item_t da_q [0:LatA-1];
	always_ff @(posedge clk) begin
		da_q[0] <= item_in;
		for (int i = 1; i < LatA; i++) da_q[i] <= da_q[i-1];
	end

	logic signed [15:0] ix, iy;
	abp_rotator #(.Stages(CORDIC_STAGES)) u_init (.clk(clk), .x_in(34'sh4000_0000),
		.y_in(34'sd0), .ang({init_angle, 16'd0}), .x_out(ix), .y_out(iy));

	// orientation after optional initialisation, plus rotation angle product
	item_t a_end, a_fix;
	logic signed [15:0] ux_a, uy_a;
	assign a_end = da_q[LatA-1];
	assign ux_a = a_end.init ? ix : a_end.ux;
	assign uy_a = a_end.init ? iy : a_end.uy;

	always_comb begin
		a_fix = a_end;
		a_fix.ux = ux_a;
		a_fix.uy = uy_a;
	end

	logic signed [32:0] th_s1;
	logic signed [63:0] p_s2;
	item_t b0_s1, b0_s2;
	always_ff @(posedge clk) begin
		th_s1 <= $signed({1'b0, rot_scale_q}) * a_end.nr;
		b0_s1 <= a_fix;
		p_s2 <= 64'(th_s1) * 64'(TurnsPerRad);
		b0_s2 <= b0_s1;
	end

	item_t db_q [0:LatB-1];
	always_ff @(posedge clk) begin
		db_q[0] <= b0_s2;
		for (int i = 1; i < LatB; i++) db_q[i] <= db_q[i-1];
	end

	logic signed [15:0] rx, ry;
	abp_rotator #(.Stages(CORDIC_STAGES)) u_noise (.clk(clk),
		.x_in({{2{b0_s2.ux[15]}}, b0_s2.ux, 16'd0}), .y_in({{2{b0_s2.uy[15]}}, b0_s2.uy, 16'd0}),
		.ang(p_s2[59:28]), .x_out(rx), .y_out(ry));

	item_t b_end;
	assign b_end = db_q[LatB-1];
	logic signed [15:0] gx, gy;
	assign gx = b_end.grp ? rx : b_end.ux;
	assign gy = b_end.grp ? ry : b_end.uy;

	logic signed [31:0] npx, npy, vx, vy;
	abp_axis u_ax (.clk(clk), .dir(rx), .force_in(b_end.fx), .noise(b_end.nx), .pos(b_end.px),
		.drive_gain(drive_gain_q), .force_gain(force_gain_q), .trans_scale(trans_scale_q),
		.inv_step(inv_step_q), .new_pos(npx), .vel(vx));
	abp_axis u_ay (.clk(clk), .dir(ry), .force_in(b_end.fy), .noise(b_end.ny), .pos(b_end.py),
		.drive_gain(drive_gain_q), .force_gain(force_gain_q), .trans_scale(trans_scale_q),
		.inv_step(inv_step_q), .new_pos(npy), .vel(vy));

	// side data for the axis stage
	typedef struct packed {
		logic signed [31:0] px, py;
		logic signed [15:0] dx, dy;
		logic grp;
	} side_t;
	side_t dc_q [0:AxLat-1];
	always_ff @(posedge clk) begin
		dc_q[0] <= '{px: b_end.px, py: b_end.py, dx: gx, dy: gy, grp: b_end.grp};
		for (int i = 1; i < AxLat; i++) dc_q[i] <= dc_q[i-1];
	end

	// valid line over the whole pipe
	logic [Total-1:0] vld_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_q <= '0;
		else vld_q <= {vld_q[Total-2:0], take};
	end

	side_t c_end;
	assign c_end = dc_q[AxLat-1];
	always_ff @(posedge clk) begin
		new_pos_x <= c_end.grp ? npx : c_end.px;
		new_pos_y <= c_end.grp ? npy : c_end.py;
		new_dir_x <= c_end.dx;
		new_dir_y <= c_end.dy;
		vel_x <= c_end.grp ? vx : 32'sd0;
		vel_y <= c_end.grp ? vy : 32'sd0;
		moved <= c_end.grp;
	end
	assign done = vld_q[Total-1];

	// results never appear without an accepted item earlier
	a_lat: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(vld_q[Total-2])) else $error("result without item");
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		!busy) else $error("busy raised");
	a_dir: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (new_dir_x <= 16'sd16384 && new_dir_x >= -16'sd16384))
		else $error("orientation out of range");
endmodule
`default_nettype wire

// File: tb/tb_active_brownian_particle_step_2d.sv
// Self-checking testbench for active_brownian_particle_step_2d: directed rows, then random
// particles under several register settings, checked against typed rows or an in-bench predictor.
// Depends on abp_pkg and the block's RTL.
`timescale 1ns / 100ps
`default_nettype none
module tb_active_brownian_particle_step_2d;
	import abp_pkg::*;

	localparam int Stages = CordicStagesDef;
	localparam int Latency = 2 * (Stages + 3) + 2 + 6;
	localparam int CycleLimit = 1000000;
	localparam int PhaseItems = 250;
	localparam int Phases = 6;

	// arctangents as fractions of a turn, Q0.32
	localparam logic [31:0] AtanTurn [0:23] = '{
		32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
		32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
		32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
		32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163, 32'd81};

	typedef struct {
		logic signed [31:0] px, py;
		logic signed [15:0] dx, dy;
		logic signed [31:0] fx, fy;
		logic signed [15:0] nr, nx, ny;
		logic        [15:0] ang;
		logic               ini, grp;
	} particle_t;

	typedef struct {
		logic signed [31:0] px, py;
		logic signed [15:0] dx, dy;
		logic signed [31:0] vx, vy;
		logic               mv;
	} step_t;

	typedef struct {
		particle_t p;
		logic      typed;	// expectation read straight off the row
	} dir_row_t;

	logic clk, arst_n;
	logic cfg_we;
	logic [2:0] cfg_index;
	logic [31:0] cfg_data;
	logic start, busy, done;
	logic signed [31:0] pos_x, pos_y, force_x, force_y;
	logic signed [15:0] dir_x, dir_y, noise_rot, noise_x, noise_y;
	logic [15:0] init_angle;
	logic init_orient, in_group;
	logic signed [31:0] new_pos_x, new_pos_y, vel_x, vel_y;
	logic signed [15:0] new_dir_x, new_dir_y;
	logic moved;

	// shadow copy of the register file
	logic [15:0] rot_scale;
	logic [31:0] trans_scale, drive_gain, force_gain, inv_step;

	step_t pending_steps[$];
	int errors;
	int cycles;
	dir_row_t dir_rows[$];

	active_brownian_particle_step_2d uut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.start(start), .busy(busy),
		.pos_x(pos_x), .pos_y(pos_y), .dir_x(dir_x), .dir_y(dir_y),
		.force_x(force_x), .force_y(force_y),
		.noise_rot(noise_rot), .noise_x(noise_x), .noise_y(noise_y),
		.init_angle(init_angle), .init_orient(init_orient), .in_group(in_group),
		.done(done), .new_pos_x(new_pos_x), .new_pos_y(new_pos_y),
		.new_dir_x(new_dir_x), .new_dir_y(new_dir_y),
		.vel_x(vel_x), .vel_y(vel_y), .moved(moved)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CycleLimit) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	task automatic report(input string what, input longint got, input longint want);
		$display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
		errors++;
	endtask

	// ---------------------------------------------------------------- predictor
	function automatic longint clampl(input longint v, input longint lo, input longint hi);
		return v < lo ? lo : (v > hi ? hi : v);
	endfunction

	// rotate a Q.30 vector by a turn fraction; quarter-turn swap, then CORDIC stages
	function automatic void rotate_vec(input longint x0, input longint y0,
			input logic [31:0] a, output logic signed [15:0] ox,
			output logic signed [15:0] oy);
		logic [31:0] q, d, half;
		longint x, y, z, t, xs, ys;
		half = a + 32'h2000_0000;
		q = {30'd0, half[31:30]};
		d = a - (q << 30);
		z = longint'(signed'(d));
		x = x0;
		y = y0;
		case (q)
			32'd1: begin t = x; x = -y; y = t; end
			32'd2: begin x = -x; y = -y; end
			32'd3: begin t = x; x = y; y = -t; end
			default: ;
		endcase
		for (int i = 0; i < Stages && i < TableLen; i++) begin
			xs = y >>> i;
			ys = x >>> i;
			if (z >= 0) begin
				x -= xs; y += ys; z -= longint'(AtanTurn[i]);
			end else begin
				x += xs; y -= ys; z += longint'(AtanTurn[i]);
			end
		end
		x = (x * longint'(CordicInvGain) + (64'sd1 <<< 45)) >>> 46;
		y = (y * longint'(CordicInvGain) + (64'sd1 <<< 45)) >>> 46;
		ox = 16'(clampl(x, -16384, 16384));
		oy = 16'(clampl(y, -16384, 16384));
	endfunction

	// displacement along one axis, Q.28
	function automatic longint axis_shift(input logic signed [15:0] u,
			input logic signed [31:0] f, input logic signed [15:0] n);
		return ((longint'(drive_gain) * longint'(u)) >>> 2)
			+ ((longint'(force_gain) * longint'(f)) >>> 4)
			+ longint'(trans_scale) * longint'(n);
	endfunction

	function automatic logic signed [31:0] speed_of(input longint d28);
		longint unsigned a, hi, lo, mag;
		a = d28 < 0 ? 64'd0 - longint'(d28) : d28;
		hi = (a >> 28) * longint'(inv_step);
		lo = ((a & 64'h0FFF_FFFF) * longint'(inv_step) + (64'd1 << 27)) >> 28;
		mag = (hi >= (64'd1 << 32)) ? (64'd1 << 32) : hi + lo;
		if (d28 < 0)
			return mag >= 64'h8000_0000 ? 32'sh8000_0000 : 32'(-longint'(mag));
		return mag >= 64'h7FFF_FFFF ? 32'sh7FFF_FFFF : 32'(mag);
	endfunction

	function automatic step_t advance_particle(input particle_t p);
		step_t r;
		longint th, prod, ddx, ddy;
		logic [31:0] turn;
		r.px = p.px; r.py = p.py; r.dx = p.dx; r.dy = p.dy;
		r.vx = '0; r.vy = '0; r.mv = p.grp;
		if (p.ini)
			rotate_vec(64'sd1 <<< 30, 0, {p.ang, 16'd0}, r.dx, r.dy);
		if (p.grp) begin
			th = longint'(rot_scale) * longint'(p.nr);
			prod = th * longint'(TurnsPerRad);
			turn = prod[59:28];
			rotate_vec(longint'(r.dx) * 65536, longint'(r.dy) * 65536, turn, r.dx, r.dy);
			ddx = axis_shift(r.dx, p.fx, p.nx);
			ddy = axis_shift(r.dy, p.fy, p.ny);
			r.px = 32'(clampl(longint'(p.px) + ((ddx + 2048) >>> 12),
				-64'sd2147483648, 64'sd2147483647));
			r.py = 32'(clampl(longint'(p.py) + ((ddy + 2048) >>> 12),
				-64'sd2147483648, 64'sd2147483647));
			r.vx = speed_of(ddx);
			r.vy = speed_of(ddy);
		end
		return r;
	endfunction

	// ---------------------------------------------------------------- result checker
	always @(posedge clk) begin
		step_t e;
		if (arst_n && done) begin
			if (pending_steps.size() == 0) begin
				report("unexpected result", 1, 0);
			end else begin
				e = pending_steps.pop_front();
				if (new_pos_x !== e.px) report("new_pos_x", new_pos_x, e.px);
				if (new_pos_y !== e.py) report("new_pos_y", new_pos_y, e.py);
				if (new_dir_x !== e.dx) report("new_dir_x", new_dir_x, e.dx);
				if (new_dir_y !== e.dy) report("new_dir_y", new_dir_y, e.dy);
				if (vel_x !== e.vx) report("vel_x", vel_x, e.vx);
				if (vel_y !== e.vy) report("vel_y", vel_y, e.vy);
				if (moved !== e.mv) report("moved", moved, e.mv);
			end
		end
	end

	// ---------------------------------------------------------------- stimulus helpers
	function automatic particle_t mk(input logic signed [31:0] px, py,
			input logic signed [15:0] dx, dy, input logic signed [31:0] fx, fy,
			input logic signed [15:0] nr, nx, ny, input logic [15:0] ang,
			input logic ini, grp);
		particle_t p;
		p.px = px; p.py = py; p.dx = dx; p.dy = dy; p.fx = fx; p.fy = fy;
		p.nr = nr; p.nx = nx; p.ny = ny; p.ang = ang; p.ini = ini; p.grp = grp;
		return p;
	endfunction

	function automatic logic signed [15:0] rand_dir();
		case ($urandom_range(0, 3))
			0: return $urandom_range(0, 1) ? 16'sd16384 : -16'sd16384;
			1: return 16'($urandom_range(0, 2048)) - 16'sd1024;
			default: return 16'(int'($urandom_range(0, 32768)) - 16384);
		endcase
	endfunction

	function automatic logic signed [31:0] rand_big();
		case ($urandom_range(0, 4))
			0: return $urandom_range(0, 1) ? 32'sh7FFF_FFF0 + $urandom_range(0, 15)
				: 32'sh8000_0000 + $urandom_range(0, 15);
			1, 2: return 32'(int'($urandom_range(0, 32'h0010_0000)) - 32'h0008_0000);
			default: return $urandom;
		endcase
	endfunction

	function automatic particle_t rand_particle();
		particle_t p;
		p.px = rand_big(); p.py = rand_big();
		p.dx = rand_dir(); p.dy = rand_dir();
		p.fx = rand_big(); p.fy = rand_big();
		p.nr = 16'($urandom); p.nx = 16'($urandom); p.ny = 16'($urandom);
		if ($urandom_range(0, 3) != 0) begin
			// typical normal samples, within about four sigma
			p.nr = 16'(int'($urandom_range(0, 16384)) - 8192);
			p.nx = 16'(int'($urandom_range(0, 16384)) - 8192);
		end
		p.ang = 16'($urandom);
		p.ini = ($urandom_range(0, 3) == 0);
		p.grp = ($urandom_range(0, 3) != 0);
		return p;
	endfunction

	// drive one particle and wait for its transfer
	task automatic send(input particle_t p, input logic typed);
		step_t e;
		@(negedge clk);
		pos_x = p.px; pos_y = p.py; dir_x = p.dx; dir_y = p.dy;
		force_x = p.fx; force_y = p.fy;
		noise_rot = p.nr; noise_x = p.nx; noise_y = p.ny;
		init_angle = p.ang; init_orient = p.ini; in_group = p.grp;
		start = 1'b1;
		do @(posedge clk); while (busy);
		if (typed) begin
			e.px = p.px; e.py = p.py; e.dx = p.dx; e.dy = p.dy;
			e.vx = '0; e.vy = '0; e.mv = 1'b0;
		end else begin
			e = advance_particle(p);
		end
		pending_steps.push_back(e);
	endtask

	// random gap with junk on the payload
	task automatic pause();
		int n;
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4, 5: n = 0;
			6, 7, 8: n = $urandom_range(1, 3);
			default: n = $urandom_range(10, 40);
		endcase
		repeat (n) begin
			@(negedge clk);
			start = 1'b0;
			pos_x = $urandom; dir_x = 16'($urandom); in_group = $urandom_range(0, 1);
		end
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
		@(negedge clk);
		start = 1'b0;
		cfg_we = 1'b1; cfg_index = idx; cfg_data = val;
		@(negedge clk);
		cfg_we = 1'b0;
		case (idx)
			RegRotScale: rot_scale = val[15:0];
			RegTransScale: trans_scale = val;
			RegDriveGain: drive_gain = val;
			RegForceGain: force_gain = val;
			RegInvStep: inv_step = val;
			default: ;	// unknown index, ignored by the block
		endcase
	endtask

	// wait for every outstanding transfer, then for the pipeline to empty
	task automatic drain();
		@(negedge clk);
		start = 1'b0;
		wait (pending_steps.size() == 0);
		repeat (Latency + 8) @(posedge clk);
	endtask

	function automatic logic [31:0] rand_reg();
		case ($urandom_range(0, 5))
			0: return 32'd0;
			1: return 32'hFFFF_FFFF;
			2: return 32'($urandom_range(0, 32'h0004_0000));
			default: return $urandom;
		endcase
	endfunction

	// ---------------------------------------------------------------- main sequence
	initial begin
		errors = 0; cycles = 0;
		cfg_we = 1'b0; cfg_index = '0; cfg_data = '0; start = 1'b0;
		pos_x = '0; pos_y = '0; dir_x = '0; dir_y = '0; force_x = '0; force_y = '0;
		noise_rot = '0; noise_x = '0; noise_y = '0; init_angle = '0;
		init_orient = 1'b0; in_group = 1'b0;
		rot_scale = '0; trans_scale = '0; drive_gain = '0; force_gain = '0;
		inv_step = 32'd65536;
		arst_n = 1'b0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed rows: passthrough rows are typed, the rest predicted
		dir_rows.push_back('{mk(0, 0, 16384, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1});
		dir_rows.push_back('{mk(32'sh7FFF_FFFF, 32'sh8000_0000, -16384, 16384,
			32'sh7FFF_FFFF, 32'sh8000_0000, 32767, -32768, 32767, 16'hFFFF, 0, 0), 1'b1});
		dir_rows.push_back('{mk(32'sh8000_0000, 32'sh7FFF_FFFF, 16384, -16384,
			32'sh8000_0000, 32'sh7FFF_FFFF, -32768, 32767, -32768, 0, 0, 0), 1'b1});
		// non-unit orientation outside the group
		dir_rows.push_back('{mk(123, -456, 16384, 16384, 5, 5, 1, 1, 1, 0, 0, 0), 1'b1});
		// init outside the group: orientation replaced, position kept
		dir_rows.push_back('{mk(1000, 2000, 0, 0, 0, 0, 0, 0, 0, 16'h0000, 1, 0), 1'b0});
		dir_rows.push_back('{mk(1000, 2000, 0, 0, 0, 0, 0, 0, 0, 16'h4000, 1, 0), 1'b0});
		dir_rows.push_back('{mk(1000, 2000, 0, 0, 0, 0, 0, 0, 0, 16'h8000, 1, 0), 1'b0});
		dir_rows.push_back('{mk(1000, 2000, 0, 0, 0, 0, 0, 0, 0, 16'hE000, 1, 0), 1'b0});
		dir_rows.push_back('{mk(1000, 2000, 0, 0, 0, 0, 0, 0, 0, 16'hFFFF, 1, 0), 1'b0});
		// in the group, unit and non-unit orientation, extreme noise and force
		dir_rows.push_back('{mk(0, 0, 16384, 0, 0, 0, 0, 0, 0, 0, 0, 1), 1'b0});
		dir_rows.push_back('{mk(0, 0, 0, -16384, 65536, -65536, 4096, 4096, -4096,
			0, 0, 1), 1'b0});
		dir_rows.push_back('{mk(32'sh7FFF_FFFF, 32'sh8000_0000, 16384, -16384,
			32'sh7FFF_FFFF, 32'sh8000_0000, 32767, 32767, -32768, 0, 0, 1), 1'b0});
		dir_rows.push_back('{mk(32'sh8000_0000, 32'sh7FFF_FFFF, -16384, 16384,
			32'sh8000_0000, 32'sh7FFF_FFFF, -32768, -32768, 32767, 0, 0, 1), 1'b0});
		dir_rows.push_back('{mk(0, 0, 16384, 16384, 0, 0, 100, 0, 0, 0, 0, 1), 1'b0});
		dir_rows.push_back('{mk(0, 0, -16384, -16384, 0, 0, -100, 0, 0, 0, 0, 1), 1'b0});
		// init and group together
		dir_rows.push_back('{mk(5, 5, 0, 0, 0, 0, 2000, 0, 0, 16'h2000, 1, 1), 1'b0});
		dir_rows.push_back('{mk(-5, -5, 0, 0, 0, 0, -2000, 0, 0, 16'hA000, 1, 1), 1'b0});

		foreach (dir_rows[i]) send(dir_rows[i].p, dir_rows[i].typed);
		drain();

		// same rows with every register at its maximum, all predicted
		write_reg(RegRotScale, 32'hFFFF_FFFF);
		write_reg(RegTransScale, 32'hFFFF_FFFF);
		write_reg(RegDriveGain, 32'hFFFF_FFFF);
		write_reg(RegForceGain, 32'hFFFF_FFFF);
		write_reg(RegInvStep, 32'hFFFF_FFFF);
		write_reg(3'd5, $urandom);
		write_reg(3'd6, $urandom);
		write_reg(3'd7, $urandom);
		foreach (dir_rows[i]) send(dir_rows[i].p, 1'b0);
		drain();

		// random phases, each under its own register setting
		for (int ph = 0; ph < Phases; ph++) begin
			if (ph == 0) begin
				// small gains, like a sane physical setup
				write_reg(RegRotScale, 32'd3000);
				write_reg(RegTransScale, 32'd2000);
				write_reg(RegDriveGain, 32'd6554);
				write_reg(RegForceGain, 32'd655);
				write_reg(RegInvStep, 32'd655360);
			end else if (ph == 1) begin
				write_reg(RegRotScale, 32'd0);
				write_reg(RegTransScale, 32'd0);
				write_reg(RegDriveGain, 32'd0);
				write_reg(RegForceGain, 32'd0);
				write_reg(RegInvStep, 32'd0);
			end else begin
				write_reg(RegRotScale, rand_reg());
				write_reg(RegTransScale, rand_reg());
				write_reg(RegDriveGain, rand_reg());
				write_reg(RegForceGain, rand_reg());
				write_reg(RegInvStep, rand_reg());
			end
			for (int k = 0; k < PhaseItems; k++) begin
				send(rand_particle(), 1'b0);
				// long bursts without gaps in places
				if (k % 64 < 40) pause();
			end
			drain();
		end

		if (errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end
endmodule
`default_nettype wire

// File: sim.f
rtl/core/abp_pkg.sv
rtl/core/abp_cell.sv
rtl/core/abp_rotator.sv
rtl/core/abp_axis.sv
rtl/core/active_brownian_particle_step_2d.sv
tb/tb_active_brownian_particle_step_2d.sv
